>>> rtl/core/bfba_pkg.sv
// Shared types and constants of the best-fit bump allocator.
// Holds the port widths, operation and status codes, controller states and
// the command and status bundles between bfba_ctrl and bfba_dp.
package bfba_pkg;

    localparam int SIZE_W     = 41;
    localparam int ADDR_W     = 40;
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 3;
    localparam int STATUS_W   = 2;

    localparam logic [SIZE_W-1:0] CAP_RESET = 41'h100_0000_0000;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_DROPPED   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_DECIDE,
        S_JOIN,
        S_APPLY,
        S_SHDN,
        S_SHUP,
        S_INS,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SPLIT,
        WR_MERGE,
        WR_SHDN,
        WR_SHUP,
        WR_NEW
    } t_wr_src;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_POS1,
        PTR_CNT,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef struct packed {
        logic    load;
        logic    scan_init;
        logic    rd_en;
        logic    rd_up;
        t_ptr_op ptr_op;
        logic    eval;
        logic    join_calc;
        t_wr_src wr_src;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_grant;
        logic    res_bump;
        logic    res_exh;
        logic    res_drop;
        logic    publish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic skip;
        logic ptr_lt_cnt;
        logic ptr_gt_pos;
        logic rd_vld;
        logic stop;
        logic hit;
        logic exact;
        logic bump_ok;
        logic jn;
        logic jp;
        logic full;
    } t_dp_sts;

endpackage

>>> rtl/core/bfba_ctrl.sv
// Sequencer of the best-fit bump allocator.
// Steps each request through scan, decision, list update and result beat.
// Depends on bfba_pkg for the state type and the command and status bundles.
module bfba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bfba_pkg::t_dp_cmd  o_cmd,
    input  bfba_pkg::t_dp_sts  i_sts
);
    import bfba_pkg::*;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_out_vld  = r_out_vld && !i_out_ready;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.scan_init = 1'b1;
                o_cmd.ptr_op    = PTR_ZERO;
                n_state = (i_sts.is_free && i_sts.skip) ? S_FIN : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.eval = 1'b1;
                if (i_sts.stop) begin
                    n_state = i_sts.is_free ? S_JOIN : S_DECIDE;
                end else if (i_sts.ptr_lt_cnt) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.ptr_op = PTR_INC;
                end else if (!i_sts.rd_vld) begin
                    n_state = i_sts.is_free ? S_JOIN : S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.hit) begin
                    o_cmd.res_grant = 1'b1;
                    if (i_sts.exact) begin
                        o_cmd.ptr_op = PTR_POS1;
                        n_state      = S_SHDN;
                    end else begin
                        o_cmd.wr_src = WR_SPLIT;
                        n_state      = S_FIN;
                    end
                end else if (i_sts.bump_ok) begin
                    o_cmd.res_bump = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.res_exh = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_JOIN: begin
                o_cmd.join_calc = 1'b1;
                n_state         = S_APPLY;
            end
            S_APPLY: begin
                if (i_sts.jn || i_sts.jp) begin
                    o_cmd.wr_src = WR_MERGE;
                    if (i_sts.jn && i_sts.jp) begin
                        o_cmd.ptr_op = PTR_POS1;
                        n_state      = S_SHDN;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (i_sts.full) begin
                    o_cmd.res_drop = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.ptr_op = PTR_CNT;
                    n_state      = S_SHUP;
                end
            end
            S_SHDN: begin
                o_cmd.wr_src = WR_SHDN;
                if (i_sts.ptr_lt_cnt) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.ptr_op = PTR_INC;
                end else if (!i_sts.rd_vld) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_SHUP: begin
                o_cmd.wr_src = WR_SHUP;
                if (i_sts.ptr_gt_pos) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_up  = 1'b1;
                    o_cmd.ptr_op = PTR_DEC;
                end else if (!i_sts.rd_vld) begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                o_cmd.wr_src  = WR_NEW;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_vld     = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;

endmodule

>>> rtl/core/bfba_dp.sv
// Datapath of the best-fit bump allocator: free-list memory, scan compare,
// merge and split arithmetic, bump pointer, capacity register and result beat.
// Depends on bfba_pkg; driven by bfba_ctrl through the command bundle.
module bfba_dp #(
    parameter int FREE_ENTRIES = 16,
    parameter int OFFSET_BITS  = 40
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bfba_pkg::t_dp_cmd               i_cmd,
    output bfba_pkg::t_dp_sts               o_sts,
    input  logic                            i_cfg_we,
    input  logic [bfba_pkg::SIZE_W-1:0]     i_cfg_data,
    input  logic                            i_op,
    input  logic [bfba_pkg::SIZE_W-1:0]     i_size,
    input  logic [bfba_pkg::ADDR_W-1:0]     i_off,
    output logic [bfba_pkg::ADDR_W-1:0]     o_res_off,
    output logic                            o_res_ff,
    output logic [bfba_pkg::STATUS_W-1:0]   o_res_st
);
    import bfba_pkg::*;

    localparam int OW = OFFSET_BITS;
    localparam int SW = OFFSET_BITS + 1;
    localparam int EW = OW + SW;
    localparam int AW = ((SW > SIZE_W) ? SW : SIZE_W) + 1;
    localparam int IW = $clog2(FREE_ENTRIES);
    localparam int CW = $clog2(FREE_ENTRIES + 1);
    localparam logic [AW-1:0] SPACE_END = AW'(1) << OFFSET_BITS;

    logic [EW-1:0]     r_mem [FREE_ENTRIES];
    logic [EW-1:0]     r_rd_data;
    logic              r_vld;
    logic [IW-1:0]     r_at;

    t_op               r_op;
    logic [AW-1:0]     r_size;
    logic [ADDR_W-1:0] r_off;
    logic [SIZE_W-1:0] r_cap;
    logic [SW-1:0]     r_bump;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_ptr;
    logic [CW-1:0]     r_pos;
    logic              r_hit;
    logic [EW-1:0]     r_sel;
    logic [EW-1:0]     r_prev;
    logic [AW-1:0]     r_bw;
    logic [AW-1:0]     r_sum;
    logic              r_jn;
    logic              r_jp;
    logic [ADDR_W-1:0] r_res_off;
    logic              r_res_ff;
    t_status           r_res_st;
    logic [ADDR_W-1:0] r_m_off;
    logic              r_m_ff;
    t_status           r_m_st;

    logic [AW-1:0] w_off_a, w_room, w_trim;
    logic [AW-1:0] w_e_off, w_e_size, w_waste;
    logic [AW-1:0] w_sel_off, w_sel_size, w_prev_off, w_prev_size;
    logic [AW-1:0] w_cap, w_bump_a, w_bump_sum;
    logic [AW-1:0] w_split_off, w_mrg_add, w_mrg_size;
    logic          w_fit, w_better, w_lt, w_stop, w_jn, w_jp;
    logic [CW-1:0] w_rd_ptr, w_pos_m1;
    logic [IW-1:0] w_rd_addr, w_wr_addr;
    logic [EW-1:0] w_wr_data;
    logic          w_wr_en;

    assign w_off_a     = AW'(r_off);
    assign w_room      = SPACE_END - w_off_a;
    assign w_trim      = (r_size > w_room) ? w_room : r_size;
    assign w_e_off     = AW'(r_rd_data[EW-1:SW]);
    assign w_e_size    = AW'(r_rd_data[SW-1:0]);
    assign w_sel_off   = AW'(r_sel[EW-1:SW]);
    assign w_sel_size  = AW'(r_sel[SW-1:0]);
    assign w_prev_off  = AW'(r_prev[EW-1:SW]);
    assign w_prev_size = AW'(r_prev[SW-1:0]);

    assign w_fit    = w_e_size >= r_size;
    assign w_waste  = w_e_size - r_size;
    assign w_better = w_fit && (!r_hit || (w_waste < r_bw));
    assign w_lt     = w_e_off < w_off_a;
    assign w_stop   = r_vld && ((r_op == OP_FREE) ? !w_lt : (w_fit && (w_waste == '0)));

    assign w_cap      = (AW'(r_cap) < SPACE_END) ? AW'(r_cap) : SPACE_END;
    assign w_bump_a   = AW'(r_bump);
    assign w_bump_sum = w_bump_a + r_size;

    assign w_jn = r_hit && ((w_off_a + r_size) == w_sel_off);
    assign w_jp = (r_pos != '0) && ((w_prev_off + w_prev_size) == w_off_a);

    assign w_split_off = w_sel_off + r_size;
    assign w_mrg_add   = r_jn ? r_sum : r_size;
    assign w_mrg_size  = w_prev_size + w_mrg_add;

    assign w_rd_ptr  = i_cmd.rd_up ? (r_ptr - CW'(1)) : r_ptr;
    assign w_rd_addr = w_rd_ptr[IW-1:0];
    assign w_pos_m1  = r_pos - CW'(1);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos[IW-1:0];
        w_wr_data = r_rd_data;
        unique case (i_cmd.wr_src)
            WR_NONE: begin
                w_wr_en = 1'b0;
            end
            WR_SPLIT: begin
                w_wr_en   = 1'b1;
                w_wr_data = {w_split_off[OW-1:0], r_bw[SW-1:0]};
            end
            WR_MERGE: begin
                w_wr_en = 1'b1;
                if (r_jp) begin
                    w_wr_addr = w_pos_m1[IW-1:0];
                    w_wr_data = {r_prev[EW-1:SW], w_mrg_size[SW-1:0]};
                end else begin
                    w_wr_data = {w_off_a[OW-1:0], r_sum[SW-1:0]};
                end
            end
            WR_SHDN: begin
                w_wr_en   = r_vld;
                w_wr_addr = r_at - IW'(1);
            end
            WR_SHUP: begin
                w_wr_en   = r_vld;
                w_wr_addr = r_at + IW'(1);
            end
            WR_NEW: begin
                w_wr_en   = 1'b1;
                w_wr_data = {w_off_a[OW-1:0], r_size[SW-1:0]};
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_bump <= '0;
            r_cnt  <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_vld <= i_cmd.rd_en;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.res_bump) begin
                r_bump <= w_bump_sum[SW-1:0];
            end
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_size <= AW'(i_size);
            r_off  <= i_off;
        end
        if (i_cmd.scan_init) begin
            r_hit     <= 1'b0;
            r_pos     <= '0;
            r_bw      <= '0;
            r_res_off <= '0;
            r_res_ff  <= 1'b0;
            r_res_st  <= ST_OK;
            if (r_op == OP_FREE) begin
                r_size <= w_trim;
            end
        end
        if (i_cmd.rd_en) begin
            r_at <= w_rd_addr;
        end
        unique case (i_cmd.ptr_op)
            PTR_HOLD: r_ptr <= r_ptr;
            PTR_ZERO: r_ptr <= '0;
            PTR_POS1: r_ptr <= r_pos + CW'(1);
            PTR_CNT:  r_ptr <= r_cnt;
            PTR_INC:  r_ptr <= r_ptr + CW'(1);
            PTR_DEC:  r_ptr <= r_ptr - CW'(1);
            default:  r_ptr <= r_ptr;
        endcase
        if (i_cmd.eval && r_vld) begin
            if (r_op == OP_FREE) begin
                if (w_lt) begin
                    r_pos  <= CW'(r_at) + CW'(1);
                    r_prev <= r_rd_data;
                end else begin
                    r_hit <= 1'b1;
                    r_sel <= r_rd_data;
                end
            end else if (w_better) begin
                r_hit <= 1'b1;
                r_pos <= CW'(r_at);
                r_sel <= r_rd_data;
                r_bw  <= w_waste;
            end
        end
        if (i_cmd.join_calc) begin
            r_jn  <= w_jn;
            r_jp  <= w_jp;
            r_sum <= r_size + w_sel_size;
        end
        if (i_cmd.res_grant) begin
            r_res_off <= w_sel_off[ADDR_W-1:0];
            r_res_ff  <= 1'b1;
        end
        if (i_cmd.res_bump) begin
            r_res_off <= w_bump_a[ADDR_W-1:0];
        end
        if (i_cmd.res_exh) begin
            r_res_st <= ST_EXHAUSTED;
        end
        if (i_cmd.res_drop) begin
            r_res_st <= ST_DROPPED;
        end
        if (i_cmd.publish) begin
            r_m_off <= r_res_off;
            r_m_ff  <= r_res_ff;
            r_m_st  <= r_res_st;
        end
    end

    assign o_sts.is_free    = (r_op == OP_FREE);
    assign o_sts.skip       = (r_size == '0) || (w_off_a >= SPACE_END);
    assign o_sts.ptr_lt_cnt = r_ptr < r_cnt;
    assign o_sts.ptr_gt_pos = r_ptr > r_pos;
    assign o_sts.rd_vld     = r_vld;
    assign o_sts.stop       = w_stop;
    assign o_sts.hit        = r_hit;
    assign o_sts.exact      = r_hit && (r_bw == '0);
    assign o_sts.bump_ok    = (w_bump_sum <= w_cap) && (w_bump_a < SPACE_END);
    assign o_sts.jn         = r_jn;
    assign o_sts.jp         = r_jp;
    assign o_sts.full       = (r_cnt == CW'(FREE_ENTRIES));

    assign o_res_off = r_m_off;
    assign o_res_ff  = r_m_ff;
    assign o_res_st  = r_m_st;

`ifndef SYNTH
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_cnt != $past(r_cnt))) |->
            ((r_cnt == ($past(r_cnt) + CW'(1))) || (r_cnt == ($past(r_cnt) - CW'(1)))))
        else $error("Free block count moved by more than one entry.");

    a_bump_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_bump >= $past(r_bump)))
        else $error("Bump pointer moved backward.");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (CW'(w_wr_addr) <= r_cnt))
        else $error("Free list write beyond the held entries.");

    a_exact_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && w_stop && (r_op == OP_ALLOC)) |=> (r_hit && (r_bw == '0)))
        else $error("Allocate scan stopped without an exact fit.");
`endif

endmodule

>>> rtl/core/best_fit_bump_allocator.sv
// Best-fit arena allocator: each request beat gives exactly one result beat.
// An allocate takes the free block of least waste (first exact fit wins,
// ties to the lowest offset), splitting off its front or removing it, and
// otherwise bumps a pointer up to min(arena capacity, 2^OFFSET_BITS); a
// free inserts the region in offset order and merges it with adjacent
// blocks, and is dropped with status 2 when it needs a slot and the list
// holds FREE_ENTRIES blocks. The free list sits in a memory with one read
// port and one write port that is scanned and shifted one entry per cycle;
// a request also waits at its end for the previous result beat to drain.
// One request is in work at a time, and the next is taken while the last
// result beat still waits. The capacity register may be written whenever
// the block is idle and is always ready.
module best_fit_bump_allocator #(
    parameter int FREE_ENTRIES = 16,
    parameter int OFFSET_BITS  = 40
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // region_size [40:0], region_offset [80:41], zero [87:81]
    input  logic [bfba_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation [0]
    input  logic [bfba_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // granted_offset [39:0]
    output logic [bfba_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // from_free_list [0], status [2:1]
    output logic [bfba_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bfba_pkg::SIZE_W-1:0]         i_cfg_data
);
    import bfba_pkg::*;

    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;
    logic [ADDR_W-1:0]   w_res_off;
    logic                w_res_ff;
    logic [STATUS_W-1:0] w_res_st;

    assign o_cfg_ready = 1'b1;

    bfba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    bfba_dp #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_op       (s_axis_tuser[0]),
        .i_size     (s_axis_tdata[SIZE_W-1:0]),
        .i_off      (s_axis_tdata[SIZE_W +: ADDR_W]),
        .o_res_off  (w_res_off),
        .o_res_ff   (w_res_ff),
        .o_res_st   (w_res_st)
    );

    assign m_axis_tdata = w_res_off;
    assign m_axis_tuser = {w_res_st, w_res_ff};

endmodule
